FILE: rtl/bbau_pkg.sv
// ----------------------------------------------------------------------------
// bbau_pkg
// Field widths, operation and status codes, and configuration register
// indexes for the block bitmap allocator.
// ----------------------------------------------------------------------------
package bbau_pkg;

  localparam int unsigned BLOCK_W    = 17;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FDB_W      = 16;
  localparam int unsigned MBU_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MBU_W-1:0] MBU_RESET = 4'd8;

  typedef logic [BLOCK_W-1:0] block_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOCATED = 3'd0,
    STATUS_FREED     = 3'd1,
    STATUS_NO_FREE   = 3'd2,
    STATUS_NULL      = 3'd3,
    STATUS_RANGE     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DATA_BLOCK = 1'b0,
    CFG_MAP_BLOCKS       = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// Disk block allocator over a free-block bitmap with a search rover. An
// allocate word starts at the bitmap block that holds the rover, takes the
// lowest clear bit there, wraps over the bitmap blocks in use, sets the bit,
// moves the rover and returns first_data_block plus the bit index; it reports
// no free block when every block in use is full. A free word ignores block 0,
// flags a number outside the map, and otherwise lowers the rover when needed
// and clears the bit. The bitmap sits in one memory of MAP_WORDS words of
// WORD_BITS bits, read through a single port at one word per cycle, and a
// lowest-clear-bit encoder examines each word as it arrives. The input is
// taken again as soon as the result moves into the output register. After
// reset a clearing pass writes zero to all MAP_WORDS words (1024 in the
// default setup), one per cycle, while in_ready_o stays low; configuration
// writes are taken at any time. BITS_PER_MAP_BLOCK and WORD_BITS are powers
// of two, and a bitmap block holds a whole number of words.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit #(
  parameter int unsigned BITS_PER_MAP_BLOCK = 8192,
  parameter int unsigned MAX_MAP_BLOCKS     = 8,
  parameter int unsigned WORD_BITS          = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bbau_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bbau_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic [bbau_pkg::BLOCK_W-1:0]         block_number_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bbau_pkg::BLOCK_W-1:0]         result_block_o,
  output logic [bbau_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned BLOCK_W    = bbau_pkg::BLOCK_W;
  localparam int unsigned TOTAL_BITS = MAX_MAP_BLOCKS * BITS_PER_MAP_BLOCK;
  localparam int unsigned MAP_WORDS  = TOTAL_BITS / WORD_BITS;
  localparam int unsigned AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned POS_W      = $clog2(WORD_BITS);
  localparam int unsigned WPB        = BITS_PER_MAP_BLOCK / WORD_BITS;
  localparam int unsigned WPB_SH     = $clog2(WPB);
  localparam int unsigned BPMB_SH    = $clog2(BITS_PER_MAP_BLOCK);
  localparam int unsigned BLK_W      = (MAX_MAP_BLOCKS > 1) ? $clog2(MAX_MAP_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_MAP_BLOCKS + 1);
  localparam int unsigned REL_W      = $clog2(TOTAL_BITS) + 1;
  localparam int unsigned N_W        = ((REL_W > BLOCK_W) ? REL_W : BLOCK_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_MOD,
    S_WRITE,
    S_DONE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bbau_pkg::FDB_W-1:0] fdb_q;
  logic [bbau_pkg::MBU_W-1:0] mbu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q <= '0;
      mbu_q <= bbau_pkg::MBU_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bbau_pkg::CFG_FIRST_DATA_BLOCK: fdb_q <= cfg_data_i[bbau_pkg::FDB_W-1:0];
        bbau_pkg::CFG_MAP_BLOCKS:       mbu_q <= cfg_data_i[bbau_pkg::MBU_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the number of bitmap blocks in use to 1..MAX_MAP_BLOCKS.
  logic [CNT_W-1:0] m_eff;
  logic [REL_W-1:0] span;

  always_comb begin
    if (mbu_q == '0) begin
      m_eff = CNT_W'(1);
    end else if (32'(mbu_q) > 32'(MAX_MAP_BLOCKS)) begin
      m_eff = CNT_W'(MAX_MAP_BLOCKS);
    end else begin
      m_eff = CNT_W'(mbu_q);
    end
  end

  assign span = REL_W'(m_eff) << BPMB_SH;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b,
                                                input logic [CNT_W-1:0] m);
    logic [CNT_W:0] inc;
    inc = (CNT_W + 1)'(b) + 1'b1;
    return (inc < (CNT_W + 1)'(m)) ? BLK_W'(b + 1'b1) : '0;
  endfunction

  function automatic logic [AW-1:0] blk_addr(input logic [BLK_W-1:0] b);
    return AW'(b) << WPB_SH;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                state_q;
  logic [AW-1:0]         clr_addr_q;
  logic [BLOCK_W-1:0]    hint_q;
  // issue side of the word scan
  logic [AW-1:0]         iss_addr_q;
  logic [BLK_W-1:0]      iss_blk_q;
  logic                  iss_live_q;
  logic [BLK_W-1:0]      start_q;
  // check side: the word whose read data is on the RAM output
  logic                  chk_v_q;
  logic [AW-1:0]         chk_addr_q;
  logic [BLK_W-1:0]      chk_blk_q;
  logic                  chk_final_q;
  // free path and write-back
  logic [AW-1:0]         free_addr_q;
  logic [POS_W-1:0]      free_pos_q;
  logic [AW-1:0]         wr_addr_q;
  logic [WORD_BITS-1:0]  wr_data_q;
  // pending and output result
  logic [BLOCK_W-1:0]    res_block_q;
  bbau_pkg::status_e     res_status_q;
  logic                  out_valid_q;
  logic [BLOCK_W-1:0]    out_block_q;
  bbau_pkg::status_e     out_status_q;

  // --------------------------------------------------------------------------
  // Bitmap memory and word scanner
  // --------------------------------------------------------------------------
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic                  zero_any;
  logic [POS_W-1:0]      zero_pos;

  // Write zeros during the clearing pass, the updated word in the write state.
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : wr_addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : wr_data_q;
  assign ram_raddr = (state_q == S_SCAN) ? iss_addr_q : free_addr_q;

  bbau_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbau_ffz #(
    .WORD_BITS (WORD_BITS)
  ) u_ffz (
    .word_i     (ram_rdata),
    .any_zero_o (zero_any),
    .pos_o      (zero_pos)
  );

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [BLOCK_W-1:0] hint_off;
  logic [BLOCK_W-1:0] hint_blk;
  logic [BLK_W-1:0]   start_blk;
  logic [BLOCK_W-1:0] free_rel;
  logic               free_in_range;

  always_comb begin
    // Start at the rover's bitmap block, or at block 0 when the rover is
    // outside the blocks in use.
    hint_off  = hint_q - BLOCK_W'(fdb_q);
    hint_blk  = hint_off >> BPMB_SH;
    start_blk = '0;
    if ((hint_q >= BLOCK_W'(fdb_q)) && (32'(hint_blk) < 32'(m_eff))) begin
      start_blk = BLK_W'(hint_blk);
    end
    free_rel      = block_number_i - BLOCK_W'(fdb_q);
    free_in_range = (block_number_i >= BLOCK_W'(fdb_q)) &&
                    (32'(free_rel) < 32'(span));
  end

  // --------------------------------------------------------------------------
  // Scan datapath
  // --------------------------------------------------------------------------
  logic                 iss_last;
  logic [BLK_W-1:0]     iss_nb;
  logic [BLK_W-1:0]     chk_nb;
  logic [N_W-1:0]       alloc_num;
  logic                 alloc_fits;
  logic [WORD_BITS-1:0] set_mask;
  logic [WORD_BITS-1:0] clr_mask;

  assign iss_last   = (iss_addr_q & AW'(WPB - 1)) == AW'(WPB - 1);
  assign iss_nb     = next_blk(iss_blk_q, m_eff);
  assign chk_nb     = next_blk(chk_blk_q, m_eff);
  assign alloc_num  = N_W'(fdb_q) + N_W'({chk_addr_q, zero_pos});
  // A clear bit whose number would not fit the result field counts as used,
  // and so does every higher bit of that bitmap block.
  assign alloc_fits = (alloc_num >> BLOCK_W) == '0;
  assign set_mask   = WORD_BITS'(1) << zero_pos;
  assign clr_mask   = WORD_BITS'(1) << free_pos_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      hint_q       <= '0;
      iss_addr_q   <= '0;
      iss_blk_q    <= '0;
      iss_live_q   <= 1'b0;
      start_q      <= '0;
      chk_v_q      <= 1'b0;
      chk_addr_q   <= '0;
      chk_blk_q    <= '0;
      chk_final_q  <= 1'b0;
      free_addr_q  <= '0;
      free_pos_q   <= '0;
      wr_addr_q    <= '0;
      wr_data_q    <= '0;
      res_block_q  <= '0;
      res_status_q <= bbau_pkg::STATUS_ALLOCATED;
      out_valid_q  <= 1'b0;
      out_block_q  <= '0;
      out_status_q <= bbau_pkg::STATUS_ALLOCATED;
    end else begin
      // drop the output word once it is taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            res_block_q <= '0;
            if (operation_i == bbau_pkg::OP_ALLOC) begin
              start_q    <= start_blk;
              iss_blk_q  <= start_blk;
              iss_addr_q <= blk_addr(start_blk);
              iss_live_q <= 1'b1;
              chk_v_q    <= 1'b0;
              state_q    <= S_SCAN;
            end else if (block_number_i == '0) begin
              res_status_q <= bbau_pkg::STATUS_NULL;
              state_q      <= S_DONE;
            end else if (!free_in_range) begin
              res_status_q <= bbau_pkg::STATUS_RANGE;
              state_q      <= S_DONE;
            end else begin
              if (block_number_i < hint_q) begin
                hint_q <= block_number_i;
              end
              free_addr_q <= AW'(free_rel >> POS_W);
              free_pos_q  <= free_rel[POS_W-1:0];
              state_q     <= S_FREE_RD;
            end
          end
        end

        S_SCAN: begin
          // issue: read one word a cycle, block by block with wraparound
          if (iss_live_q) begin
            chk_v_q     <= 1'b1;
            chk_addr_q  <= iss_addr_q;
            chk_blk_q   <= iss_blk_q;
            chk_final_q <= iss_last && (iss_nb == start_q);
            if (iss_last) begin
              if (iss_nb == start_q) begin
                iss_live_q <= 1'b0;
              end else begin
                iss_blk_q  <= iss_nb;
                iss_addr_q <= blk_addr(iss_nb);
              end
            end else begin
              iss_addr_q <= iss_addr_q + 1'b1;
            end
          end else begin
            chk_v_q <= 1'b0;
          end

          // check: examine the word just read; this overrides the issue side
          if (chk_v_q) begin
            if (zero_any) begin
              if (alloc_fits) begin
                wr_addr_q    <= chk_addr_q;
                wr_data_q    <= ram_rdata | set_mask;
                hint_q       <= alloc_num[BLOCK_W-1:0];
                res_block_q  <= alloc_num[BLOCK_W-1:0];
                res_status_q <= bbau_pkg::STATUS_ALLOCATED;
                state_q      <= S_WRITE;
              end else if (chk_nb == start_q) begin
                res_status_q <= bbau_pkg::STATUS_NO_FREE;
                state_q      <= S_DONE;
              end else begin
                // skip the rest of this bitmap block, discard the read in flight
                iss_blk_q  <= chk_nb;
                iss_addr_q <= blk_addr(chk_nb);
                iss_live_q <= 1'b1;
                chk_v_q    <= 1'b0;
              end
            end else if (chk_final_q) begin
              res_status_q <= bbau_pkg::STATUS_NO_FREE;
              state_q      <= S_DONE;
            end
          end
        end

        S_FREE_RD: begin
          state_q <= S_FREE_MOD;
        end

        S_FREE_MOD: begin
          wr_addr_q    <= free_addr_q;
          wr_data_q    <= ram_rdata & ~clr_mask;
          res_status_q <= bbau_pkg::STATUS_FREED;
          state_q      <= S_WRITE;
        end

        S_WRITE: begin
          state_q <= S_DONE;
        end

        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_block_q  <= res_block_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_block_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  // Only an allocate reports a block number.
  a_block_zero_unless_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != bbau_pkg::STATUS_ALLOCATED)) |-> (result_block_o == '0))
    else $error("nonzero block number on a result that is not an allocation");

  // One word at a time: the input closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a word is in progress");

  // The scan never looks at a bitmap block beyond those in use.
  a_scan_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && chk_v_q) |-> (32'(chk_blk_q) < 32'(m_eff)))
    else $error("scan reached a bitmap block beyond those in use");

  // A fresh allocation leaves the rover on the returned block.
  a_rover_follows_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && (status_o == bbau_pkg::STATUS_ALLOCATED))
      |-> (hint_q == result_block_o))
    else $error("rover does not match the allocated block");
`endif

endmodule

FILE: rtl/bbau_map_ram.sv
// ----------------------------------------------------------------------------
// bbau_map_ram
// Free-block bitmap storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bbau_map_ram #(
  parameter  int unsigned DEPTH = 1024,
  parameter  int unsigned WIDTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bbau_ffz.sv
// ----------------------------------------------------------------------------
// bbau_ffz
// Find the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bbau_ffz #(
  parameter  int unsigned WORD_BITS = 64,
  localparam int unsigned POS_W     = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 any_zero_o,
  output logic [POS_W-1:0]     pos_o
);

  always_comb begin
    any_zero_o = ~&word_i;
    pos_o      = '0;
    // scan from the top so the lowest clear bit wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        pos_o = POS_W'(i);
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_bitmap_allocator_unit. Request words go in
// through a valid/ready channel; a bit-accurate allocator in the bench keeps
// its own bitmap, rover and register copies and queues the reply each
// accepted word must produce. A checker pops and compares every reply. Runs
// directed edge words, fills one map block to exhaustion, stalls the reply
// side for a long stretch and then sweeps random traffic over several
// register settings.
// ----------------------------------------------------------------------------
module tb;

  import bbau_pkg::*;

  // Geometry of the instance under test (matches the defaults).
  localparam int unsigned BITS_PER_MAP_BLOCK  = 8192;
  localparam int unsigned MAX_MAP_BLOCKS      = 8;
  localparam int unsigned WORD_BITS           = 64;
  localparam int unsigned MAP_WORDS           = BITS_PER_MAP_BLOCK * MAX_MAP_BLOCKS / WORD_BITS;
  localparam int unsigned WORDS_PER_MAP_BLOCK = BITS_PER_MAP_BLOCK / WORD_BITS;
  localparam int unsigned BLOCK_MAX           = (1 << BLOCK_W) - 1;
  localparam block_t      TOP_BLOCK           = '1;

  // Longest allocate is about one pass over the whole map; the clearing pass
  // after reset is as long. Allow many times either before giving up.
  localparam int unsigned STALL_LIMIT  = 12000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned IDLE_MAX     = 18;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    block_t  blk;
    status_e st;
  } reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [BLOCK_W-1:0]    block_number_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [BLOCK_W-1:0]    result_block_o;
  logic [STATUS_W-1:0]   status_o;

  block_bitmap_allocator_unit #(
    .BITS_PER_MAP_BLOCK(BITS_PER_MAP_BLOCK),
    .MAX_MAP_BLOCKS    (MAX_MAP_BLOCKS),
    .WORD_BITS         (WORD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .block_number_i(block_number_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_block_o(result_block_o),
    .status_o      (status_o)
  );

  // Bench copy of the allocator state and registers.
  bit [WORD_BITS-1:0] alloc_map [MAP_WORDS];
  int unsigned        rover;
  int unsigned        cfg_first_block;
  int unsigned        cfg_map_blocks;

  // Replies owed by the block, oldest first, and the offsets (from the first
  // data block) of blocks the bench currently holds and may hand back.
  reply_t      due_replies [$];
  int unsigned held_offsets [$];

  // Shared knobs: per-word idle range, and a one-shot long hold for the
  // reply side.
  int unsigned idle_max = IDLE_MAX;
  int unsigned hold_len = 0;

  int unsigned mismatches    = 0;
  int unsigned replies_seen  = 0;
  int unsigned alloc_words   = 0;
  int unsigned free_words    = 0;
  int unsigned exhausted     = 0;
  int unsigned null_frees    = 0;
  int unsigned range_frees   = 0;
  int unsigned reg_writes    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Allocator model
  // --------------------------------------------------------------------------

  // Bitmap blocks searched: zero acts as one, anything above the map clamps.
  function automatic int unsigned blocks_searched();
    if (cfg_map_blocks < 1) return 1;
    if (cfg_map_blocks > MAX_MAP_BLOCKS) return MAX_MAP_BLOCKS;
    return cfg_map_blocks;
  endfunction

  // Lowest clear bit inside one bitmap block, -1 when the block is full.
  function automatic int lowest_clear(input int unsigned blk);
    int unsigned w;
    int unsigned b;
    int          pos;
    pos = -1;
    for (w = blk * WORDS_PER_MAP_BLOCK;
         w < (blk + 1) * WORDS_PER_MAP_BLOCK && pos < 0; w++) begin
      if (alloc_map[w] != '1) begin
        for (b = 0; b < WORD_BITS && pos < 0; b++) begin
          if (!alloc_map[w][b]) pos = (w - blk * WORDS_PER_MAP_BLOCK) * WORD_BITS + b;
        end
      end
    end
    return pos;
  endfunction

  // Apply one request word to the model and return the reply it owes.
  function automatic void allocate_or_free(input op_e op, input block_t num,
                                           output block_t res, output status_e st);
    int unsigned used;
    int unsigned span;
    int unsigned start;
    int unsigned blk;
    int unsigned rel;
    int unsigned n;
    int          pos;
    bit          found;
    used  = blocks_searched();
    span  = used * BITS_PER_MAP_BLOCK;
    res   = '0;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      // Start at the rover's bitmap block unless the rover is off the map.
      start = 0;
      if (rover >= cfg_first_block &&
          (rover - cfg_first_block) / BITS_PER_MAP_BLOCK < used) begin
        start = (rover - cfg_first_block) / BITS_PER_MAP_BLOCK;
      end
      st  = STATUS_NO_FREE;
      blk = start;
      do begin
        pos = lowest_clear(blk);
        if (pos >= 0) begin
          rel = blk * BITS_PER_MAP_BLOCK + pos;
          n   = cfg_first_block + rel;
          // A number too wide for the port counts as in use.
          if (n <= BLOCK_MAX) begin
            alloc_map[rel / WORD_BITS][rel % WORD_BITS] = 1'b1;
            rover = n;
            res   = block_t'(n);
            st    = STATUS_ALLOCATED;
            found = 1'b1;
          end
        end
        blk = (blk + 1 < used) ? blk + 1 : 0;
      end while (!found && blk != start);
    end else if (num == '0) begin
      st = STATUS_NULL;
    end else if (num < cfg_first_block || (num - cfg_first_block) >= span) begin
      st = STATUS_RANGE;
    end else begin
      if (num < rover) rover = num;
      rel = num - cfg_first_block;
      alloc_map[rel / WORD_BITS][rel % WORD_BITS] = 1'b0;
      st = STATUS_FREED;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  function automatic block_t random_block();
    return block_t'($urandom_range(0, BLOCK_MAX));
  endfunction

  // Hand back a block the bench holds; fall back to any number.
  function automatic block_t pick_held_block();
    int unsigned idx;
    int unsigned off;
    if (held_offsets.size() == 0) return random_block();
    idx = $urandom_range(0, held_offsets.size() - 1);
    off = held_offsets[idx];
    held_offsets.delete(idx);
    return block_t'(cfg_first_block + off);
  endfunction

  // Offer one request word, hold it until taken, then book its reply.
  task automatic send_word(input op_e op, input block_t num);
    int unsigned gap;
    block_t      want_blk;
    status_e     want_st;
    gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    block_number_i <= num;
    do @(posedge clk_i); while (!in_ready_o);
    allocate_or_free(op, num, want_blk, want_st);
    due_replies.push_back('{want_blk, want_st});
    if (op == OP_ALLOC) alloc_words++;
    else free_words++;
    case (want_st)
      STATUS_ALLOCATED: held_offsets.push_back(want_blk - cfg_first_block);
      STATUS_NO_FREE:   exhausted++;
      STATUS_NULL:      null_frees++;
      STATUS_RANGE:     range_frees++;
      default:          ;
    endcase
  endtask

  // Drop valid and wait for every owed reply; the block is then idle since
  // each word yields exactly one reply.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_FIRST_DATA_BLOCK: cfg_first_block = value[FDB_W-1:0];
      CFG_MAP_BLOCKS:       cfg_map_blocks  = value[MBU_W-1:0];
      default:              ;
    endcase
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly allocates and returns of held blocks, with some noise frees.
  task automatic send_random_mix(input int unsigned count);
    int unsigned i;
    int unsigned pick;
    int unsigned span;
    block_t      edge_blk;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      span = blocks_searched() * BITS_PER_MAP_BLOCK;
      if (pick < 45) begin
        send_word(OP_ALLOC, random_block());
      end else if (pick < 80) begin
        send_word(OP_FREE, pick_held_block());
      end else if (pick < 88) begin
        send_word(OP_FREE, random_block());
      end else if (pick < 92) begin
        send_word(OP_FREE, '0);
      end else begin
        case ($urandom_range(0, 4))
          0:       edge_blk = block_t'(cfg_first_block - 1);
          1:       edge_blk = block_t'(cfg_first_block);
          2:       edge_blk = block_t'(cfg_first_block + span - 1);
          3:       edge_blk = block_t'(cfg_first_block + span);
          default: edge_blk = TOP_BLOCK;
        endcase
        send_word(OP_FREE, edge_blk);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edge words on reset values first, then on shifted and clamped settings.
  task automatic test_directed_edges();
    send_word(OP_ALLOC, TOP_BLOCK);         // first block 0: null block handed out
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, '0);                 // null free is ignored
    send_word(OP_FREE, 17'd1);
    send_word(OP_FREE, 17'd1);              // double free
    send_word(OP_FREE, 17'd65535);          // last block of the full map
    send_word(OP_FREE, 17'd65536);          // one past the map
    send_word(OP_FREE, TOP_BLOCK);
    send_word(OP_ALLOC, 17'h0AAAA);
    write_reg(CFG_FIRST_DATA_BLOCK, 16'hFFFF);
    write_reg(CFG_MAP_BLOCKS, 16'h000F);    // above the map: clamps to eight
    send_word(OP_ALLOC, 17'h15555);         // rover below first block: start at 0
    send_word(OP_FREE, 17'd65534);          // below first block
    send_word(OP_FREE, 17'd65535);
    send_word(OP_FREE, TOP_BLOCK);          // past the end
    send_word(OP_FREE, 17'h1FFFE);          // highest block in range
    send_word(OP_ALLOC, '0);
    write_reg(CFG_MAP_BLOCKS, 16'hFFF0);    // low nibble zero acts as one block
    send_word(OP_FREE, 17'd73727);
    send_word(OP_FREE, 17'd73726);
    write_reg(CFG_FIRST_DATA_BLOCK, 16'h0000);
    write_reg(CFG_MAP_BLOCKS, 16'h0008);
    send_word(OP_FREE, 17'd24581);          // rover drops into map block 3
    send_word(OP_ALLOC, '0);
    write_reg(CFG_MAP_BLOCKS, 16'h0002);    // rover now past the blocks in use
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 17'd16383);
    send_word(OP_FREE, 17'd16384);
  endtask

  // Fill a single map block back to back until it reports no free block,
  // punch a few holes and refill them.
  task automatic test_map_exhaustion();
    int unsigned i;
    idle_max = 0;
    write_reg(CFG_FIRST_DATA_BLOCK, CFG_DATA_W'($urandom_range(1, 50000)));
    write_reg(CFG_MAP_BLOCKS, 16'h0001);
    for (i = 0; i < BITS_PER_MAP_BLOCK + 3; i++) send_word(OP_ALLOC, random_block());
    for (i = 0; i < 3; i++) begin
      send_word(OP_FREE,
                block_t'(cfg_first_block + $urandom_range(0, BITS_PER_MAP_BLOCK - 1)));
    end
    for (i = 0; i < 5; i++) send_word(OP_ALLOC, random_block());
    idle_max = IDLE_MAX;
  endtask

  // Hold the reply side off for a long stretch while requests keep coming,
  // so the block backs up and stalls its input.
  task automatic test_result_stall();
    int unsigned i;
    write_reg(CFG_MAP_BLOCKS, 16'h0008);
    hold_len = HOLD_CYCLES;
    for (i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_word(OP_FREE, pick_held_block());
      else send_word(OP_ALLOC, random_block());
    end
  endtask

  // Random traffic over extreme and random register settings.
  task automatic test_random_settings();
    int unsigned phase;
    logic [CFG_DATA_W-1:0] first_val;
    logic [CFG_DATA_W-1:0] blocks_val;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin first_val = 16'h0000; blocks_val = 16'h0008; end
        1: begin first_val = 16'hFFFF; blocks_val = 16'h000F; end
        2: begin first_val = CFG_DATA_W'($urandom()); blocks_val = 16'h0001; end
        3: begin
          first_val  = CFG_DATA_W'($urandom_range(1, 2000));
          blocks_val = CFG_DATA_W'($urandom_range(2, 7));
        end
        4: begin first_val = 16'h0001; blocks_val = 16'h0000; end
        default: begin
          first_val  = CFG_DATA_W'($urandom());
          blocks_val = CFG_DATA_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(CFG_FIRST_DATA_BLOCK, first_val);
      write_reg(CFG_MAP_BLOCKS, blocks_val);
      send_random_mix(100);
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply side: draw a stall per reply, take it, compare with the oldest
  // owed reply.
  // --------------------------------------------------------------------------
  initial begin : reply_checker
    int unsigned stall;
    reply_t      want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      replies_seen++;
      if (due_replies.size() == 0) begin
        if (mismatches < 10) begin
          $display("reply %0d: none owed, got block %0d status %0d",
                   replies_seen, result_block_o, status_o);
        end
        mismatches++;
      end else begin
        want = due_replies.pop_front();
        if (result_block_o !== want.blk || status_o !== want.st) begin
          if (mismatches < 10) begin
            $display("reply %0d: expected block %0d status %0d, got block %0d status %0d",
                     replies_seen, want.blk, want.st, result_block_o, status_o);
          end
          mismatches++;
        end
      end
    end
  end

  // Give up when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("block_bitmap_allocator_unit: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    int unsigned w;
    for (w = 0; w < MAP_WORDS; w++) alloc_map[w] = '0;
    rover           = 0;
    cfg_first_block = 0;
    cfg_map_blocks  = MBU_RESET;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    operation_i    <= 1'b0;
    block_number_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block clears its map after reset; the first word simply waits.
    test_directed_edges();
    test_map_exhaustion();
    test_result_stall();
    test_random_settings();

    // Drain, then watch a full allocate time for stray replies.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d allocate and %0d free words across %0d register writes, %0d replies",
             alloc_words, free_words, reg_writes, replies_seen);
    $display("saw %0d full-map, %0d null and %0d out-of-range replies; %0d mismatches",
             exhausted, null_frees, range_frees, mismatches);
    if (mismatches == 0) begin
      $display("block_bitmap_allocator_unit: match");
    end else begin
      $display("block_bitmap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bbau_pkg.sv
rtl/bbau_map_ram.sv
rtl/bbau_ffz.sv
rtl/block_bitmap_allocator_unit.sv
tb/tb.sv
